// ===== rtl/core/pss_pkg.sv =====
// Shared types and constants for the process slot scheduler.
// No dependencies; used by pss_slot_table, process_slot_scheduler and the bench.
package pss_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int SLEEP_W = 16;
  localparam int SLICE_W = 8;
  localparam int IDX_OUT_W = 4;
  localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 8'd16;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_status_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_FORK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECR,
    S_SLICE,
    S_PICK,
    S_COMMIT,
    S_FORK
  } seq_state_t;

  // Write request into the slot table at the sequencer's current address.
  typedef struct packed {
    logic               status_we;
    slot_status_t       status;
    logic               sleep_we;
    logic [SLEEP_W-1:0] sleep;
    logic               slice_we;
    logic [SLICE_W-1:0] slice;
  } tbl_wr_t;

  // Contents of the addressed slot.
  typedef struct packed {
    slot_status_t       status;
    logic [SLEEP_W-1:0] sleep;
    logic [SLICE_W-1:0] slice;
  } tbl_rd_t;

endpackage

// ===== rtl/core/pss_slot_table.sv =====
// Slot table of the process slot scheduler: status, sleep countdown and
// slice count per slot, one addressed slot read and written per cycle.
// Depends on pss_pkg.
module pss_slot_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pss_pkg::SLOT_W-1:0]   addr,
  input  pss_pkg::tbl_wr_t             wr,
  output pss_pkg::tbl_rd_t             rd
);

  pss_pkg::slot_status_t             status_r [pss_pkg::NUM_SLOTS];
  logic [pss_pkg::SLEEP_W-1:0]       sleep_r  [pss_pkg::NUM_SLOTS];
  logic [pss_pkg::SLICE_W-1:0]       slice_r  [pss_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pss_pkg::NUM_SLOTS; i++) begin
        status_r[i] <= (i == 0) ? pss_pkg::ST_RUNNING : pss_pkg::ST_DEAD;
        sleep_r[i]  <= '0;
        slice_r[i]  <= '0;
      end
    end else begin
      if (wr.status_we) begin
        status_r[addr] <= wr.status;
      end
      if (wr.sleep_we) begin
        sleep_r[addr] <= wr.sleep;
      end
      if (wr.slice_we) begin
        slice_r[addr] <= wr.slice;
      end
    end
  end

  assign rd.status = status_r[addr];
  assign rd.sleep  = sleep_r[addr];
  assign rd.slice  = slice_r[addr];

endmodule

// ===== rtl/core/process_slot_scheduler.sv =====
// Top level of the process slot scheduler: event sequencer and result register.
// Depends on pss_pkg and pss_slot_table.
//
// Usage: an event (tick, sleep, exit or fork, chosen by in_action) is taken at a
// rising edge where start is high and busy is low. in_sleep_ticks matters only
// for sleep. Each event yields exactly one result, shown on the out_ ports for
// a single cycle with out_valid high; the receiver cannot stall it. The user
// must write the slice limit via cfg_we/cfg_wdata only while idle: unenforced.
//
// Timing: one slot per cycle passes through a shared decrement/compare unit.
// A tick, exit or nonzero sleep keeps busy high through a countdown over every
// slot and a slice step, plus selection and commit steps when the current slot
// gives up the processor. A fork keeps busy high while scanning for a dead slot.
// The result shows in the first cycle with busy low, when the next event may
// already be accepted; a zero-length sleep never raises busy and answers in the
// cycle after it.
//
// Reset: slot 0 is running and current, all other slots are dead with cleared
// counters, and the slice limit returns to 16.
module process_slot_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic [pss_pkg::SLEEP_W-1:0]       in_sleep_ticks,
  input  logic                              cfg_we,
  input  logic [pss_pkg::SLICE_W-1:0]       cfg_wdata,
  output logic                              out_valid,
  output logic [pss_pkg::IDX_OUT_W-1:0]     out_current_slot,
  output logic                              out_switched,
  output logic                              out_fork_ok,
  output logic [pss_pkg::IDX_OUT_W-1:0]     out_child_slot
);

  localparam logic [pss_pkg::SLOT_W-1:0] LAST_IDX = pss_pkg::SLOT_W'(pss_pkg::NUM_SLOTS - 1);

  pss_pkg::seq_state_t               state_r, state_nxt;
  logic [pss_pkg::SLOT_W-1:0]        cnt_r, cnt_nxt;
  logic [pss_pkg::SLOT_W-1:0]        cur_r, cur_nxt;
  logic [pss_pkg::SLOT_W-1:0]        pick_r, pick_nxt;
  logic [pss_pkg::SLICE_W-1:0]       limit_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [pss_pkg::IDX_OUT_W-1:0]     out_cur_r, out_cur_nxt;
  logic                              out_sw_r, out_sw_nxt;
  logic                              out_ok_r, out_ok_nxt;
  logic [pss_pkg::IDX_OUT_W-1:0]     out_child_r, out_child_nxt;

  logic [pss_pkg::SLOT_W-1:0]        addr;
  pss_pkg::tbl_wr_t                  wr;
  pss_pkg::tbl_rd_t                  rd;
  logic [pss_pkg::SLEEP_W-1:0]       sleep_dec;
  logic                              last;

  pss_slot_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (addr),
    .wr    (wr),
    .rd    (rd)
  );

  always_comb begin
    unique case (state_r)
      pss_pkg::S_IDLE,
      pss_pkg::S_SLICE:  addr = cur_r;
      pss_pkg::S_COMMIT: addr = pick_r;
      default:           addr = cnt_r;
    endcase
  end

  assign sleep_dec = rd.sleep - pss_pkg::SLEEP_W'(1);
  assign last      = (cnt_r == LAST_IDX);
  assign busy      = (state_r != pss_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pss_pkg::S_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      pick_r      <= '0;
      limit_r     <= pss_pkg::SLICE_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_cur_r   <= out_cur_nxt;
    out_sw_r    <= out_sw_nxt;
    out_ok_r    <= out_ok_nxt;
    out_child_r <= out_child_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    pick_nxt      = pick_r;
    wr            = '0;
    out_valid_nxt = 1'b0;
    out_cur_nxt   = pss_pkg::IDX_OUT_W'(cur_r);
    out_sw_nxt    = 1'b0;
    out_ok_nxt    = 1'b0;
    out_child_nxt = '0;

    unique case (state_r)
      pss_pkg::S_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          unique case (pss_pkg::action_t'(in_action))
            pss_pkg::ACT_TICK: begin
              state_nxt = pss_pkg::S_DECR;
            end
            pss_pkg::ACT_SLEEP: begin
              if (in_sleep_ticks == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                wr.status_we = 1'b1;
                wr.status    = pss_pkg::ST_BLOCKED;
                wr.sleep_we  = 1'b1;
                wr.sleep     = in_sleep_ticks;
                state_nxt    = pss_pkg::S_DECR;
              end
            end
            pss_pkg::ACT_EXIT: begin
              wr.status_we = 1'b1;
              wr.status    = pss_pkg::ST_DEAD;
              state_nxt    = pss_pkg::S_DECR;
            end
            pss_pkg::ACT_FORK: begin
              state_nxt = pss_pkg::S_FORK;
            end
            default: begin
              state_nxt = pss_pkg::S_IDLE;
            end
          endcase
        end
      end

      pss_pkg::S_DECR: begin
        if (rd.status == pss_pkg::ST_BLOCKED) begin
          wr.sleep_we = 1'b1;
          wr.sleep    = sleep_dec;
          if (sleep_dec == '0) begin
            wr.status_we = 1'b1;
            wr.status    = pss_pkg::ST_RUNNABLE;
          end
        end
        if (last) begin
          state_nxt = pss_pkg::S_SLICE;
        end else begin
          cnt_nxt = cnt_r + pss_pkg::SLOT_W'(1);
        end
      end

      pss_pkg::S_SLICE: begin
        cnt_nxt = '0;
        if (rd.status == pss_pkg::ST_RUNNING && rd.slice < limit_r) begin
          wr.slice_we   = 1'b1;
          wr.slice      = rd.slice + pss_pkg::SLICE_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = pss_pkg::S_IDLE;
        end else begin
          // A slot at its limit is preempted; any other state needs a new pick.
          if (rd.status == pss_pkg::ST_RUNNING) begin
            wr.slice_we  = 1'b1;
            wr.slice     = '0;
            wr.status_we = 1'b1;
            wr.status    = pss_pkg::ST_RUNNABLE;
          end
          state_nxt = pss_pkg::S_PICK;
        end
      end

      pss_pkg::S_PICK: begin
        if (cnt_r != cur_r && rd.status == pss_pkg::ST_RUNNABLE) begin
          pick_nxt  = cnt_r;
          state_nxt = pss_pkg::S_COMMIT;
        end else if (last) begin
          // No other slot is runnable: fall back to the idle slot, slot 0.
          pick_nxt  = '0;
          state_nxt = pss_pkg::S_COMMIT;
        end else begin
          cnt_nxt = cnt_r + pss_pkg::SLOT_W'(1);
        end
      end

      pss_pkg::S_COMMIT: begin
        wr.status_we  = 1'b1;
        wr.status     = pss_pkg::ST_RUNNING;
        cur_nxt       = pick_r;
        out_valid_nxt = 1'b1;
        out_cur_nxt   = pss_pkg::IDX_OUT_W'(pick_r);
        out_sw_nxt    = 1'b1;
        state_nxt     = pss_pkg::S_IDLE;
      end

      pss_pkg::S_FORK: begin
        if (rd.status == pss_pkg::ST_DEAD) begin
          wr.status_we  = 1'b1;
          wr.status     = pss_pkg::ST_RUNNABLE;
          wr.sleep_we   = 1'b1;
          wr.sleep      = '0;
          wr.slice_we   = 1'b1;
          wr.slice      = '0;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_child_nxt = pss_pkg::IDX_OUT_W'(cnt_r);
          state_nxt     = pss_pkg::S_IDLE;
        end else if (last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pss_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + pss_pkg::SLOT_W'(1);
        end
      end

      default: begin
        state_nxt = pss_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_current_slot = out_cur_r;
  assign out_switched     = out_sw_r;
  assign out_fork_ok      = out_ok_r;
  assign out_child_slot   = out_child_r;

endmodule

// ===== bench/process_slot_scheduler_test.sv =====
// Self-checking testbench for process_slot_scheduler: random and directed scheduler events
// are checked against an in-bench prediction of the slot table. Depends on pss_pkg and the RTL.
module process_slot_scheduler_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    pss_pkg::action_t            act;
    logic [pss_pkg::SLEEP_W-1:0] ticks;
    int unsigned                 gap;
  } sched_event_t;

  typedef struct packed {
    logic [pss_pkg::IDX_OUT_W-1:0] current_slot;
    logic                          switched;
    logic                          fork_ok;
    logic [pss_pkg::IDX_OUT_W-1:0] child_slot;
  } sched_outcome_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    in_action = pss_pkg::ACT_TICK;
  logic [pss_pkg::SLEEP_W-1:0]   in_sleep_ticks = '0;
  logic                          cfg_we = 1'b0;
  logic [pss_pkg::SLICE_W-1:0]   cfg_wdata = '0;
  logic                          out_valid;
  logic [pss_pkg::IDX_OUT_W-1:0] out_current_slot;
  logic                          out_switched;
  logic                          out_fork_ok;
  logic [pss_pkg::IDX_OUT_W-1:0] out_child_slot;

  process_slot_scheduler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_sleep_ticks   (in_sleep_ticks),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_current_slot (out_current_slot),
    .out_switched     (out_switched),
    .out_fork_ok      (out_fork_ok),
    .out_child_slot   (out_child_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted scheduler state.
  pss_pkg::slot_status_t       slot_state [pss_pkg::NUM_SLOTS];
  logic [pss_pkg::SLEEP_W-1:0] nap_left   [pss_pkg::NUM_SLOTS];
  logic [pss_pkg::SLICE_W-1:0] slice_used [pss_pkg::NUM_SLOTS];
  logic [pss_pkg::SLOT_W-1:0]  cur_slot;
  logic [pss_pkg::SLICE_W-1:0] model_slice_limit;

  sched_event_t   event_q [$];
  sched_outcome_t outcome_q [$];
  sched_event_t   staged;
  bit             staged_valid = 1'b0;
  int unsigned    gap_left = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles = 0;

  function automatic void reset_schedule();
    for (int i = 0; i < pss_pkg::NUM_SLOTS; i++) begin
      slot_state[i] = pss_pkg::ST_DEAD;
      nap_left[i] = '0;
      slice_used[i] = '0;
    end
    slot_state[0] = pss_pkg::ST_RUNNING;
    cur_slot = '0;
    model_slice_limit = pss_pkg::SLICE_LIMIT_RST;
  endfunction

  // One timer tick: count down sleepers, charge the running slot, reselect if needed.
  function automatic bit tick_schedule();
    logic [pss_pkg::SLOT_W-1:0] pick;
    pick = '0;
    for (int i = 0; i < pss_pkg::NUM_SLOTS; i++) begin
      if (slot_state[i] == pss_pkg::ST_BLOCKED) begin
        nap_left[i] = nap_left[i] - pss_pkg::SLEEP_W'(1);
        if (nap_left[i] == '0) slot_state[i] = pss_pkg::ST_RUNNABLE;
      end
    end
    if (slot_state[cur_slot] == pss_pkg::ST_RUNNING) begin
      if (slice_used[cur_slot] < model_slice_limit) begin
        slice_used[cur_slot] = slice_used[cur_slot] + pss_pkg::SLICE_W'(1);
      end else begin
        slice_used[cur_slot] = '0;
        slot_state[cur_slot] = pss_pkg::ST_RUNNABLE;
      end
    end
    if (slot_state[cur_slot] == pss_pkg::ST_RUNNING) return 1'b0;
    // Slot 0 is the fallback whatever its status.
    for (int i = 0; i < pss_pkg::NUM_SLOTS; i++) begin
      if (pss_pkg::SLOT_W'(i) != cur_slot && slot_state[i] == pss_pkg::ST_RUNNABLE) begin
        pick = pss_pkg::SLOT_W'(i);
        break;
      end
    end
    cur_slot = pick;
    slot_state[pick] = pss_pkg::ST_RUNNING;
    return 1'b1;
  endfunction

  function automatic sched_outcome_t schedule_event(pss_pkg::action_t act,
                                                    logic [pss_pkg::SLEEP_W-1:0] ticks);
    sched_outcome_t res;
    res = '0;
    case (act)
      pss_pkg::ACT_TICK: res.switched = tick_schedule();
      pss_pkg::ACT_SLEEP: begin
        if (ticks != '0) begin
          slot_state[cur_slot] = pss_pkg::ST_BLOCKED;
          nap_left[cur_slot] = ticks;
          res.switched = tick_schedule();
        end
      end
      pss_pkg::ACT_EXIT: begin
        slot_state[cur_slot] = pss_pkg::ST_DEAD;
        res.switched = tick_schedule();
      end
      default: begin
        for (int i = 0; i < pss_pkg::NUM_SLOTS; i++) begin
          if (slot_state[i] == pss_pkg::ST_DEAD) begin
            slot_state[i] = pss_pkg::ST_RUNNABLE;
            slice_used[i] = '0;
            nap_left[i] = '0;
            res.fork_ok = 1'b1;
            res.child_slot = pss_pkg::IDX_OUT_W'(i);
            break;
          end
        end
      end
    endcase
    res.current_slot = pss_pkg::IDX_OUT_W'(cur_slot);
    return res;
  endfunction

  // Driver: holds each staged event for its gap, then presents it until accepted.
  always @(posedge clk) begin
    logic next_start;
    next_start = 1'b0;
    if (!rst_n) begin
      staged_valid = 1'b0;
      in_action <= pss_pkg::ACT_TICK;
      in_sleep_ticks <= '0;
    end else if (start && busy) begin
      next_start = 1'b1;
    end else begin
      if (start) begin
        outcome_q.push_back(schedule_event(pss_pkg::action_t'(in_action), in_sleep_ticks));
        staged_valid = 1'b0;
      end
      if (!staged_valid && event_q.size() > 0) begin
        staged = event_q.pop_front();
        staged_valid = 1'b1;
        gap_left = staged.gap;
      end
      if (staged_valid) begin
        if (gap_left == 0) begin
          next_start = 1'b1;
          in_action <= staged.act;
          in_sleep_ticks <= staged.ticks;
        end else begin
          gap_left--;
        end
      end
    end
    start <= next_start;
  end

  task automatic check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    sched_outcome_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual slot %0d", $time,
                 out_current_slot);
      end else begin
        want = outcome_q.pop_front();
        check_field("current_slot", 32'(want.current_slot), 32'(out_current_slot));
        check_field("switched", 32'(want.switched), 32'(out_switched));
        check_field("fork_ok", 32'(want.fork_ok), 32'(out_fork_ok));
        check_field("child_slot", 32'(want.child_slot), 32'(out_child_slot));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_event(pss_pkg::action_t act, logic [pss_pkg::SLEEP_W-1:0] ticks);
    sched_event_t ev;
    ev.act = act;
    ev.ticks = ticks;
    ev.gap = $urandom_range(0, 5);
    event_q.push_back(ev);
  endtask

  // Mostly short sleeps so slots keep cycling; rare long ones park a slot for good.
  task automatic queue_random_events(int unsigned count, int unsigned fork_pct);
    sched_event_t ev;
    int unsigned pct;
    bit no_gaps;
    no_gaps = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pct = $urandom_range(0, 99);
      ev.ticks = pss_pkg::SLEEP_W'($urandom);
      if (pct < fork_pct) ev.act = pss_pkg::ACT_FORK;
      else if (pct < fork_pct + 15) ev.act = pss_pkg::ACT_EXIT;
      else if (pct < fork_pct + 35) ev.act = pss_pkg::ACT_SLEEP;
      else ev.act = pss_pkg::ACT_TICK;
      if (ev.act == pss_pkg::ACT_SLEEP) begin
        pct = $urandom_range(0, 99);
        if (pct < 8) ev.ticks = '0;
        else if (pct < 93) ev.ticks = pss_pkg::SLEEP_W'($urandom_range(1, 12));
        else if (pct < 99) ev.ticks = pss_pkg::SLEEP_W'($urandom_range(13, 400));
      end
      ev.gap = no_gaps ? 0 : $urandom_range(0, 5);
      event_q.push_back(ev);
    end
  endtask

  // Waits until every queued transaction is accepted and every result has come back.
  task automatic drain();
    while (event_q.size() != 0 || staged_valid || start || outcome_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slice_limit(logic [pss_pkg::SLICE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    model_slice_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [pss_pkg::SLICE_W-1:0] limits [6];
    int unsigned fork_pcts [6];
    limits = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd4};
    limits[4] = pss_pkg::SLICE_W'($urandom_range(3, 254));
    fork_pcts = '{30, 25, 45, 25, 30, 35};
    reset_schedule();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset slice limit.
    queue_event(pss_pkg::ACT_TICK, 16'h0000);
    queue_event(pss_pkg::ACT_SLEEP, 16'h0000);
    // Slot 0 alone: long sleeps fall back to slot 0 itself.
    queue_event(pss_pkg::ACT_SLEEP, 16'hFFFF);
    queue_event(pss_pkg::ACT_SLEEP, 16'hAAAA);
    queue_event(pss_pkg::ACT_SLEEP, 16'h5555);
    queue_event(pss_pkg::ACT_FORK, 16'hFFFF);
    queue_event(pss_pkg::ACT_FORK, 16'h0000);
    queue_event(pss_pkg::ACT_SLEEP, 16'h0001);
    queue_event(pss_pkg::ACT_TICK, 16'h0000);
    queue_event(pss_pkg::ACT_SLEEP, 16'h0002);
    queue_event(pss_pkg::ACT_EXIT, 16'h0000);
    queue_event(pss_pkg::ACT_TICK, 16'h0000);
    queue_event(pss_pkg::ACT_EXIT, 16'h0000);
    // The last live slot exits, so slot 0 is revived.
    queue_event(pss_pkg::ACT_EXIT, 16'h0000);
    queue_event(pss_pkg::ACT_EXIT, 16'h0000);
    queue_event(pss_pkg::ACT_TICK, 16'h0000);
    queue_random_events(120, 30);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_slice_limit(limits[p]);
      queue_random_events(305, fork_pcts[p]);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pss_pkg.sv
rtl/core/pss_slot_table.sv
rtl/core/process_slot_scheduler.sv
bench/process_slot_scheduler_test.sv
